// ===== rtl/dst_pkg.sv =====
package dst_pkg;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DN_W    = 23;
  localparam int SPAN_W  = 22;

  // Year arithmetic runs on year + 399, which fits in 15 bits for any 14-bit year
  localparam int YEXT_W = 15;
  localparam int Q_W    = 8;
  localparam int SUM_W  = 25;

  // Year offset that keeps the leap-day counts non-negative
  localparam logic [YEXT_W-1:0] YEAR_BIAS = YEXT_W'(399);

  // Days in one 400-year cycle plus the days in the years 1..1969
  localparam logic [SUM_W-1:0] EPOCH_OFFSET = SUM_W'(146097 + 719162);

  localparam logic [SUM_W-1:0] DAYS_PER_YEAR = SUM_W'(365);

  // Largest day number a 23-bit signed result can hold
  localparam logic signed [SUM_W-1:0] DN_SAT = SUM_W'(4194303);
  localparam logic signed [DN_W:0]    SPAN_SAT = (DN_W + 1)'(4194303);

  // Reciprocal for division by 100, exact for operands below 2**15
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = 28;

  localparam logic [YEXT_W-1:0] CENTURY = YEXT_W'(100);

  // Month index limits after clamping to 1..12
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic [DAY_W-1:0]   day_of_month;
    logic [MONTH_W-1:0] month_of_year;
    logic [YEAR_W-1:0]  calendar_year;
    logic               last_of_set;
  } in_item_t;

  typedef struct packed {
    logic signed [DN_W-1:0] day_number;
    logic [SPAN_W-1:0]      span_days;
    logic                   set_done;
  } out_item_t;

  // Floor of v / 100 by reciprocal multiplication
  function automatic logic [Q_W-1:0] div100(input logic [YEXT_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(DIV100_MUL);
    return Q_W'(p >> DIV100_SHIFT);
  endfunction

  // Days before the first of a month, month given as 1..12
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      MONTH_W'(1):  d = 9'd0;
      MONTH_W'(2):  d = 9'd31;
      MONTH_W'(3):  d = 9'd59;
      MONTH_W'(4):  d = 9'd90;
      MONTH_W'(5):  d = 9'd120;
      MONTH_W'(6):  d = 9'd151;
      MONTH_W'(7):  d = 9'd181;
      MONTH_W'(8):  d = 9'd212;
      MONTH_W'(9):  d = 9'd243;
      MONTH_W'(10): d = 9'd273;
      MONTH_W'(11): d = 9'd304;
      MONTH_W'(12): d = 9'd334;
      default:      d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/date_span_tracker_top.sv =====
// Converts one Gregorian date per item into a day number (1970-01-01 is day 1,
// earlier dates go negative, values above 4194303 saturate) and reports the
// span between the earliest and latest day number of the current set; an item
// with last_of_set closes the set and clears the trackers. Day and month are
// not checked: month 0 counts as January, months above 12 as December, and
// out-of-range days spill into the neighboring month. One item is taken every
// clock cycle while no result waits on out_ready; a result passes through the
// input register, quotient stage, day-number stage and result register, and
// the whole pipeline holds while a result waits on out_ready.
module date_span_tracker_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dst_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dst_pkg::out_item_t   out_item
);

  // Stage 0: input register
  logic              v0_r;
  dst_pkg::in_item_t in0_r;

  // Stage 1: quotients of year by 100
  logic                         v1_r;
  dst_pkg::in_item_t            in1_r;
  logic [dst_pkg::YEXT_W-1:0]   n1_r;
  logic [dst_pkg::Q_W-1:0]      qn1_r;
  logic [dst_pkg::Q_W-1:0]      qy1_r;

  logic [dst_pkg::YEXT_W-1:0]   n_nxt;
  logic [dst_pkg::Q_W-1:0]      qn_nxt;
  logic [dst_pkg::Q_W-1:0]      qy_nxt;

  // Stage 2: day number
  logic                         v2_r;
  logic                         last2_r;
  logic signed [dst_pkg::DN_W-1:0] dn2_r;

  logic                         leap;
  logic [dst_pkg::MONTH_W-1:0]  mi;
  logic [dst_pkg::SUM_W-1:0]    sum_u;
  logic signed [dst_pkg::SUM_W-1:0] sum_s;
  logic signed [dst_pkg::DN_W-1:0]  dn_nxt;

  // Stage 3: trackers and result register
  logic                             out_valid_r;
  dst_pkg::out_item_t               out_item_r;
  logic signed [dst_pkg::DN_W-1:0]  earliest_r;
  logic signed [dst_pkg::DN_W-1:0]  latest_r;
  logic                             started_r;

  logic signed [dst_pkg::DN_W-1:0]  earliest_nxt;
  logic signed [dst_pkg::DN_W-1:0]  latest_nxt;
  logic signed [dst_pkg::DN_W:0]    span_full;
  logic [dst_pkg::SPAN_W-1:0]       span_nxt;

  // Pipeline enable: everything moves unless a result is stuck at the output
  logic en;
  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  // Biased year and its quotients by 100
  always_comb begin
    n_nxt  = dst_pkg::YEXT_W'(in0_r.calendar_year) + dst_pkg::YEAR_BIAS;
    qn_nxt = dst_pkg::div100(n_nxt);
    qy_nxt = dst_pkg::div100(dst_pkg::YEXT_W'(in0_r.calendar_year));
  end

  // Leap rule, month clamp and closed-form day count
  always_comb begin
    leap = (in1_r.calendar_year[1:0] == 2'b00) &&
           ((dst_pkg::YEXT_W'(in1_r.calendar_year) !=
             dst_pkg::YEXT_W'(qy1_r) * dst_pkg::CENTURY) ||
            (qy1_r[1:0] == 2'b00));

    if (in1_r.month_of_year < dst_pkg::MONTH_JAN) begin
      mi = dst_pkg::MONTH_JAN;
    end else if (in1_r.month_of_year > dst_pkg::MONTH_DEC) begin
      mi = dst_pkg::MONTH_DEC;
    end else begin
      mi = in1_r.month_of_year;
    end

    sum_u = dst_pkg::SUM_W'(n1_r) * dst_pkg::DAYS_PER_YEAR
          + dst_pkg::SUM_W'(n1_r >> 2)
          - dst_pkg::SUM_W'(qn1_r)
          + dst_pkg::SUM_W'(qn1_r >> 2)
          - dst_pkg::EPOCH_OFFSET
          + dst_pkg::SUM_W'(dst_pkg::days_before_month(mi))
          + dst_pkg::SUM_W'((mi > dst_pkg::MONTH_FEB) && leap)
          + dst_pkg::SUM_W'(in1_r.day_of_month);
    sum_s = $signed(sum_u);

    // Saturate at the top of the signed range
    if (sum_s > dst_pkg::DN_SAT) begin
      dn_nxt = dst_pkg::DN_W'(dst_pkg::DN_SAT);
    end else begin
      dn_nxt = dst_pkg::DN_W'(sum_s);
    end
  end

  // Update earliest and latest, then form the clamped span
  always_comb begin
    if (!started_r) begin
      earliest_nxt = dn2_r;
      latest_nxt   = dn2_r;
    end else begin
      earliest_nxt = (dn2_r < earliest_r) ? dn2_r : earliest_r;
      latest_nxt   = (dn2_r > latest_r) ? dn2_r : latest_r;
    end
    span_full = {latest_nxt[dst_pkg::DN_W-1], latest_nxt}
              - {earliest_nxt[dst_pkg::DN_W-1], earliest_nxt};
    if (span_full > dst_pkg::SPAN_SAT) begin
      span_nxt = dst_pkg::SPAN_W'(dst_pkg::SPAN_SAT);
    end else begin
      span_nxt = dst_pkg::SPAN_W'(span_full);
    end
  end

  // Advance valid bits and trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      earliest_r  <= '0;
      latest_r    <= '0;
      started_r   <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
      if (v2_r) begin
        // Closing item clears the trackers for the next set
        if (last2_r) begin
          earliest_r <= '0;
          latest_r   <= '0;
          started_r  <= 1'b0;
        end else begin
          earliest_r <= earliest_nxt;
          latest_r   <= latest_nxt;
          started_r  <= 1'b1;
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      in0_r   <= in_item;
      in1_r   <= in0_r;
      n1_r    <= n_nxt;
      qn1_r   <= qn_nxt;
      qy1_r   <= qy_nxt;
      dn2_r   <= dn_nxt;
      last2_r <= in1_r.last_of_set;
      if (v2_r) begin
        out_item_r.day_number <= dn2_r;
        out_item_r.span_days  <= span_nxt;
        out_item_r.set_done   <= last2_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/dst_checker.sv =====
module dst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dst_pkg::out_item_t out_item
);

  // Track the span of the last delivered item and whether its set is open
  logic [dst_pkg::SPAN_W-1:0] prev_span_r;
  logic                       prev_open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_span_r <= '0;
      prev_open_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_span_r <= out_item.span_days;
      prev_open_r <= !out_item.set_done;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // First item of a set has no span
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !prev_open_r |-> out_item.span_days == '0)
    else $error("first item of a set with nonzero span");

  // Span never shrinks within a set
  a_span_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_open_r |-> out_item.span_days >= prev_span_r)
    else $error("span decreased within a set");

  // Input is always ready while no result is waiting at the output
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind date_span_tracker_top dst_checker u_dst_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int RANDOM_ITEMS  = 480;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_PRINTED   = 40;
  localparam longint DAY_CEIL  = 4194303;
  localparam longint SPAN_CEIL = 4194303;

  // Track the day-number window of the open set and the results still owed
  class span_ledger;
    dst_pkg::out_item_t due_results[$];
    logic signed [dst_pkg::DN_W-1:0] earliest;
    logic signed [dst_pkg::DN_W-1:0] latest;
    bit started;
    int mismatches;

    function new();
      earliest = '0;
      latest = '0;
      started = 1'b0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // Closed-form Gregorian date to day number, 1970-01-01 is day 1
    function logic signed [dst_pkg::DN_W-1:0] days_since_epoch(
        logic [dst_pkg::DAY_W-1:0] d,
        logic [dst_pkg::MONTH_W-1:0] m,
        logic [dst_pkg::YEAR_W-1:0] y);
      int month_start [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      longint n;
      longint v;
      int mi;
      bit leap;
      n = longint'(y) + 399;
      v = 365 * n + n / 4 - n / 100 + n / 400 - 146097 - 719162;
      // clamp month into January..December
      if (m < 1) mi = 1;
      else if (m > 12) mi = 12;
      else mi = int'(m);
      v += month_start[mi - 1];
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      if (mi > 2 && leap) v += 1;
      v += longint'(d);
      if (v > DAY_CEIL) v = DAY_CEIL;
      return dst_pkg::DN_W'(v);
    endfunction

    function void note_date(dst_pkg::in_item_t it);
      logic signed [dst_pkg::DN_W-1:0] dn;
      longint span;
      dst_pkg::out_item_t exp_item;
      dn = days_since_epoch(it.day_of_month, it.month_of_year, it.calendar_year);
      if (!started) begin
        earliest = dn;
        latest = dn;
        started = 1'b1;
      end else begin
        if (dn < earliest) earliest = dn;
        if (dn > latest) latest = dn;
      end
      span = longint'(latest) - longint'(earliest);
      if (span > SPAN_CEIL) span = SPAN_CEIL;
      exp_item.day_number = dn;
      exp_item.span_days = dst_pkg::SPAN_W'(span);
      exp_item.set_done = it.last_of_set;
      due_results.push_back(exp_item);
      // closing date clears the window
      if (it.last_of_set) begin
        earliest = '0;
        latest = '0;
        started = 1'b0;
      end
    endfunction

    task check_result(dst_pkg::out_item_t got);
      dst_pkg::out_item_t exp_item;
      if (due_results.size() == 0) begin
        report_mismatch("result item with none expected");
        return;
      end
      exp_item = due_results.pop_front();
      if (got.day_number !== exp_item.day_number)
        report_mismatch($sformatf("day_number %0d, expected %0d",
                                  got.day_number, exp_item.day_number));
      if (got.span_days !== exp_item.span_days)
        report_mismatch($sformatf("span_days %0d, expected %0d",
                                  got.span_days, exp_item.span_days));
      if (got.set_done !== exp_item.set_done)
        report_mismatch($sformatf("set_done %0b, expected %0b",
                                  got.set_done, exp_item.set_done));
    endtask

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dst_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dst_pkg::out_item_t out_item;
  logic               steady = 1'b0;
  int                 cycle_count = 0;

  span_ledger book = new();

  date_span_tracker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at random, never during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_item);
    if (rst_n && in_valid && in_ready) book.note_date(in_item);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, book.outstanding());
      $display("** date_span_tracker_top: FAILED **");
      $finish;
    end
  end

  function automatic dst_pkg::in_item_t make_date(int d, int m, int y, bit last);
    dst_pkg::in_item_t it;
    it.day_of_month = dst_pkg::DAY_W'(d);
    it.month_of_year = dst_pkg::MONTH_W'(m);
    it.calendar_year = dst_pkg::YEAR_W'(y);
    it.last_of_set = last;
    return it;
  endfunction

  // Mostly valid dates, some near the epoch, some over the full field ranges
  function automatic dst_pkg::in_item_t random_date(bit last);
    int d;
    int m;
    int y;
    int pick;
    d = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 31) : $urandom_range(0, 31);
    m = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(0, 15);
    pick = $urandom_range(0, 99);
    if (pick < 60) y = $urandom_range(1, 9999);
    else if (pick < 75) y = $urandom_range(1900, 2100);
    else if (pick < 85) y = $urandom_range(1960, 1980);
    else y = $urandom_range(0, 16383);
    return make_date(d, m, y, last);
  endfunction

  // Present one item, after an occasional random gap outside the steady stretch, and hold it until taken
  task automatic send_date(input dst_pkg::in_item_t it);
    bit taken;
    if (!steady && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (book.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    dst_pkg::in_item_t directed [$];
    int sent;
    int set_len;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // epoch alone, then a two-date set straddling it
    directed.push_back(make_date(1, 1, 1970, 1'b1));
    directed.push_back(make_date(31, 12, 1969, 1'b0));
    directed.push_back(make_date(2, 1, 1970, 1'b1));
    // lowest and highest field values, saturating day number and span
    directed.push_back(make_date(0, 0, 0, 1'b0));
    directed.push_back(make_date(31, 15, 16383, 1'b1));
    // leap rule around century years
    directed.push_back(make_date(29, 2, 2000, 1'b0));
    directed.push_back(make_date(1, 3, 2000, 1'b0));
    directed.push_back(make_date(1, 3, 1900, 1'b0));
    directed.push_back(make_date(29, 2, 2100, 1'b0));
    directed.push_back(make_date(1, 3, 2400, 1'b1));
    // widest span inside the nominal year range
    directed.push_back(make_date(1, 1, 1, 1'b0));
    directed.push_back(make_date(31, 12, 9999, 1'b1));
    // unchecked day and month: day zero, month past December, month zero
    directed.push_back(make_date(0, 3, 2023, 1'b0));
    directed.push_back(make_date(1, 13, 2023, 1'b0));
    directed.push_back(make_date(31, 0, 2023, 1'b0));
    directed.push_back(make_date(31, 2, 2023, 1'b1));
    // year zero counts as leap
    directed.push_back(make_date(1, 3, 0, 1'b0));
    directed.push_back(make_date(31, 12, 1600, 1'b1));
    // dates before the epoch only
    directed.push_back(make_date(1, 1, 1969, 1'b0));
    directed.push_back(make_date(29, 2, 1968, 1'b0));
    directed.push_back(make_date(15, 7, 1000, 1'b1));
    foreach (directed[i]) send_date(directed[i]);
    hold_until_drained();

    // random sets of one to eight dates
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_len = $urandom_range(1, 8);
      for (int k = 0; k < set_len; k++) begin
        if (sent == 150) steady <= 1'b1;
        if (sent == 300) steady <= 1'b0;
        send_date(random_date(k == set_len - 1));
        sent++;
      end
      if (sent >= 300 && sent < 309) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.outstanding() == 0) begin
      $display("** date_span_tracker_top: PASSED **");
    end else begin
      $display("** date_span_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dst_pkg.sv
rtl/date_span_tracker_top.sv
rtl/dst_checker.sv
test/testbench.sv
